### hw/rtl/rfae_pkg.sv
// Shared types, constants and helpers for the rotor flux angle estimator.
// No dependencies; imported by the top level and its checker.
`default_nettype none
package rfae_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam longint TWO_PI_Q24 = 64'sd105414357;
    localparam int REG_W = 31;

    localparam logic [0:0] REG_STEP_PERIOD = 1'b0;
    localparam logic [0:0] REG_ROTOR_TAU   = 1'b1;

    localparam logic ACT_STEP    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [REG_W-1:0] PERIOD_RST = 31'd7;
    localparam logic [REG_W-1:0] TAU_RST    = 31'd6554;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATIO_DIV,
        ST_RATIO_SAT,
        ST_DIFF_MUL,
        ST_MAG_UPD,
        ST_DEN_MUL,
        ST_DEN_CHK,
        ST_SLIP_DIV,
        ST_SLIP_SAT,
        ST_SLIP_MUL,
        ST_SLIP_SUM,
        ST_SLIP_RCP,
        ST_SLIP_QM,
        ST_SLIP_SUB,
        ST_SLIP_FIX,
        ST_ROT_MUL,
        ST_ROT_SUM,
        ST_ROT_RCP,
        ST_ROT_QM,
        ST_ROT_SUB,
        ST_ROT_FIX,
        ST_FLUX,
        ST_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < 64'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/rotor_flux_angle_estimator.sv
// Rotor flux angle estimator: magnetizing current lag, slip speed, angle integration.
// One shared multiplier (also wraps angles by reciprocal) and one radix-2 divider.
// Depends on rfae_pkg.
// Each estimator step runs two divider passes (ratio, then slip); a zero slip divisor skips the
// second. A restart word goes straight to the output state. One word at a time: ready again
// in the cycle after the output register loads, which waits while the output stalls.
// Reset: synchronous active low; registers to 7 and 6554, estimator state to its start values.
`default_nettype none
module rotor_flux_angle_estimator #(
    parameter int FRAC_BITS = rfae_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [95:0] i_s_tdata,   // torque_current, flux_current, rotor_speed
    input  wire logic [0:0]  i_s_tuser,   // action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [87:0]      o_m_tdata,   // flux_angle, sync_speed, magnetizing_current, pad
    output logic [0:0]       o_m_tuser,   // divide_fault
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);
    import rfae_pkg::*;

    localparam longint TWO_PI_L = TWO_PI_Q24 >>> (24 - FRAC_BITS);
    localparam int ANG_W = $clog2(TWO_PI_L);
    localparam logic [ANG_W-1:0] TWO_PI = ANG_W'(TWO_PI_L);
    localparam longint RCP_L = (64'sd1 <<< 32) / TWO_PI_L;
    localparam logic signed [32:0] RCP = 33'(RCP_L);
    localparam int DIV_W = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W);

    t_state r_state, n_state;

    logic [REG_W-1:0] r_per, r_tau;
    logic signed [31:0] r_iqs, r_ids, r_wr;
    logic signed [31:0] r_ratio, r_diff, r_imr, r_slip, r_sync;
    logic [ANG_W-1:0] r_sacc, r_racc, r_flux;
    logic r_fault;
    logic signed [65:0] r_prod;

    logic [DIV_W-1:0] r_quo;
    logic [31:0] r_rem, r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic r_dneg;

    logic [31:0] r_amag;
    logic r_aneg;
    logic [ANG_W:0] r_mrem;

    logic r_ovalid;
    logic [ANG_W-1:0] r_o_flux;
    logic signed [31:0] r_o_sync, r_o_imr;
    logic r_o_fault;

    logic in_acc;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [31:0] prod_sh;
    logic div_ld;
    logic [DIV_W-1:0] div_num;
    logic [31:0] div_dvs;
    logic div_neg;
    logic div_last;
    logic [32:0] rem_sh;
    logic rem_ge;
    logic signed [31:0] quo_s;
    logic [ANG_W-1:0] acc_sel, wrap_v, mod_red;
    logic signed [33:0] ang_sum, ang_mag;
    logic [31:0] mod_diff;
    logic [31:0] iqs_mag, den_mag;
    logic signed [31:0] den_v;
    logic [ANG_W:0] fsum;
    logic [ANG_W+18:0] flux_ext;

    assign in_acc   = i_s_tvalid && o_s_tready;
    assign mul_p    = mul_a * mul_b;
    assign prod_sh  = sat32(64'(r_prod >>> FRAC_BITS));
    assign div_last = (r_cnt == CNT_W'(DIV_W - 1));
    assign rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_dvs});
    assign den_v    = prod_sh;
    assign den_mag  = den_v[31] ? 32'(-den_v) : den_v;
    assign iqs_mag  = r_iqs[31] ? 32'(-r_iqs) : r_iqs;
    assign acc_sel  = (r_state == ST_ROT_SUM) ? r_racc : r_sacc;
    assign ang_sum  = $signed({{(34 - ANG_W){1'b0}}, acc_sel}) + 34'(prod_sh);
    assign ang_mag  = ang_sum[33] ? -ang_sum : ang_sum;
    assign mod_diff = r_amag - r_prod[31:0];
    assign mod_red  = (r_mrem >= {1'b0, TWO_PI}) ? ANG_W'(r_mrem - {1'b0, TWO_PI})
                                                 : r_mrem[ANG_W-1:0];
    assign wrap_v   = (r_aneg && (mod_red != '0)) ? ANG_W'(TWO_PI - mod_red) : mod_red;
    assign fsum     = {1'b0, r_sacc} + {1'b0, r_racc};
    assign flux_ext = {19'd0, r_o_flux};

    always_comb begin
        if (r_dneg) begin
            if (r_quo > DIV_W'(33'h0_8000_0000)) begin
                quo_s = S32_MIN;
            end else begin
                quo_s = 32'(~r_quo[31:0] + 32'd1);
            end
        end else if (r_quo > DIV_W'(32'h7FFF_FFFF)) begin
            quo_s = S32_MAX;
        end else begin
            quo_s = r_quo[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_tuser[0] == ACT_RESTART) ? ST_OUT : ST_RATIO_DIV;
                end
            end
            ST_RATIO_DIV: if (div_last) n_state = ST_RATIO_SAT;
            ST_RATIO_SAT: n_state = ST_DIFF_MUL;
            ST_DIFF_MUL:  n_state = ST_MAG_UPD;
            ST_MAG_UPD:   n_state = ST_DEN_MUL;
            ST_DEN_MUL:   n_state = ST_DEN_CHK;
            ST_DEN_CHK:   n_state = (den_v == 32'sd0) ? ST_SLIP_MUL : ST_SLIP_DIV;
            ST_SLIP_DIV:  if (div_last) n_state = ST_SLIP_SAT;
            ST_SLIP_SAT:  n_state = ST_SLIP_MUL;
            ST_SLIP_MUL:  n_state = ST_SLIP_SUM;
            ST_SLIP_SUM:  n_state = ST_SLIP_RCP;
            ST_SLIP_RCP:  n_state = ST_SLIP_QM;
            ST_SLIP_QM:   n_state = ST_SLIP_SUB;
            ST_SLIP_SUB:  n_state = ST_SLIP_FIX;
            ST_SLIP_FIX:  n_state = ST_ROT_MUL;
            ST_ROT_MUL:   n_state = ST_ROT_SUM;
            ST_ROT_SUM:   n_state = ST_ROT_RCP;
            ST_ROT_RCP:   n_state = ST_ROT_QM;
            ST_ROT_QM:    n_state = ST_ROT_SUB;
            ST_ROT_SUB:   n_state = ST_ROT_FIX;
            ST_ROT_FIX:   n_state = ST_FLUX;
            ST_FLUX:      n_state = ST_OUT;
            ST_OUT:       if (!r_ovalid || i_m_tready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
        mul_a   = 33'(r_ratio);
        mul_b   = 33'(r_diff);
        div_ld  = 1'b0;
        div_num = '0;
        div_dvs = '0;
        div_neg = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                div_ld  = in_acc;
                div_num = {1'b0, r_per, FRAC_BITS'(0)};
                div_dvs = {1'b0, r_tau};
            end
            ST_DEN_MUL: begin
                mul_a = $signed({2'b00, r_tau});
                mul_b = 33'(r_imr);
            end
            ST_DEN_CHK: begin
                div_ld  = (den_v != 32'sd0);
                div_num = {iqs_mag, FRAC_BITS'(0)};
                div_dvs = den_mag;
                div_neg = r_iqs[31] ^ den_v[31];
            end
            ST_SLIP_MUL: begin
                mul_a = 33'(r_slip);
                mul_b = $signed({2'b00, r_per});
            end
            ST_ROT_MUL: begin
                mul_a = 33'(r_wr);
                mul_b = $signed({2'b00, r_per});
            end
            ST_SLIP_RCP, ST_ROT_RCP: begin
                mul_a = $signed({1'b0, r_amag});
                mul_b = RCP;
            end
            ST_SLIP_QM, ST_ROT_QM: begin
                mul_a = $signed({1'b0, r_prod[63:32]});
                mul_b = $signed({{(33 - ANG_W){1'b0}}, TWO_PI});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_per   <= PERIOD_RST;
            r_tau   <= TAU_RST;
            r_imr   <= 32'sd1;
            r_sacc  <= '0;
            r_racc  <= '0;
            r_flux  <= ANG_W'(1);
            r_sync  <= 32'sd1;
            r_fault <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_STEP_PERIOD: r_per <= i_cfg_data;
                    REG_ROTOR_TAU:   r_tau <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_OUT) && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_fault <= 1'b0;
                        if (i_s_tuser[0] == ACT_RESTART) begin
                            r_imr  <= 32'sd1;
                            r_sacc <= '0;
                            r_racc <= '0;
                            r_flux <= ANG_W'(1);
                            r_sync <= 32'sd1;
                        end
                    end
                end
                ST_MAG_UPD: r_imr <= sat32(64'(r_imr) + 64'(prod_sh));
                ST_DEN_CHK: begin
                    if (den_v == 32'sd0) begin
                        r_fault <= 1'b1;
                    end
                end
                ST_SLIP_FIX: r_sacc <= wrap_v;
                ST_ROT_FIX:  r_racc <= wrap_v;
                ST_FLUX: begin
                    r_flux <= (fsum >= {1'b0, TWO_PI}) ? ANG_W'(fsum - {1'b0, TWO_PI})
                                                       : fsum[ANG_W-1:0];
                end
                ST_SLIP_MUL: r_sync <= sat32(64'(r_wr) + 64'(r_slip));
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (div_ld) begin
            r_quo  <= div_num;
            r_rem  <= '0;
            r_dvs  <= div_dvs;
            r_dneg <= div_neg;
            r_cnt  <= '0;
        end else begin
            r_quo <= {r_quo[DIV_W-2:0], rem_ge};
            r_rem <= rem_ge ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_iqs <= i_s_tdata[31:0];
                    r_ids <= i_s_tdata[63:32];
                    r_wr  <= i_s_tdata[95:64];
                end
            end
            ST_RATIO_SAT: begin
                r_ratio <= (r_tau == '0) ? S32_MAX : quo_s;
                r_diff  <= sat32(64'(r_ids) - 64'(r_imr));
            end
            ST_DEN_CHK: begin
                if (den_v == 32'sd0) begin
                    r_slip <= r_iqs[31] ? S32_MIN : S32_MAX;
                end
            end
            ST_SLIP_SAT: r_slip <= quo_s;
            ST_SLIP_SUM, ST_ROT_SUM: begin
                r_amag <= ang_mag[31:0];
                r_aneg <= ang_sum[33];
            end
            ST_SLIP_SUB, ST_ROT_SUB: r_mrem <= mod_diff[ANG_W:0];
            ST_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    r_o_flux  <= r_flux;
                    r_o_sync  <= r_sync;
                    r_o_imr   <= r_imr;
                    r_o_fault <= r_fault;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_o_imr, r_o_sync, flux_ext[18:0]};
    assign o_m_tuser  = r_o_fault;

endmodule
`default_nettype wire

### hw/rtl/rfae_checker.sv
// Port-level checks for the rotor flux angle estimator, bound to its top level.
// Depends on rfae_pkg and rotor_flux_angle_estimator.
`default_nettype none
module rfae_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [0:0]  i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [87:0] o_m_tdata,
    input wire logic [0:0]  o_m_tuser
);
    import rfae_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a word is in progress");

    a_restart_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser[0] == ACT_RESTART) && !o_m_tvalid)
        |=> ##1 (o_m_tvalid && (o_m_tdata[82:51] == 32'd1) && (o_m_tdata[50:19] == 32'd1)
                 && (o_m_tuser[0] == 1'b0)))
        else $error("restart word did not report start state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled output word changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("reset did not clear handshake state");

endmodule

bind rotor_flux_angle_estimator rfae_checker u_rfae_checker (.*);
`default_nettype wire

### tb/tb_rotor_flux_angle_estimator.sv
// Self-checking testbench for rotor_flux_angle_estimator: directed and random words,
// a bit-accurate predictor of the estimator step, and random source and sink idling.
// Depends on rfae_pkg and the estimator RTL.
`default_nettype none
module tb_rotor_flux_angle_estimator;
    import rfae_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint TWO_PI_FX = TWO_PI_Q24 >>> (24 - FB);
    localparam longint ONE_FX = 64'sd1 <<< FB;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [30:0] REG_MAX = 31'h7FFF_FFFF;

    typedef struct {
        logic              restart;
        logic signed [31:0] iqs;
        logic signed [31:0] ids;
        logic signed [31:0] wr;
    } t_est_in;

    typedef struct {
        logic [18:0]        angle;
        logic signed [31:0] sync;
        logic signed [31:0] imr;
        logic               fault;
    } t_est_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_idx = '0;
    logic [30:0] cfg_data = '0;

    rotor_flux_angle_estimator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_est_in  pending_words[$];
    t_est_out expected_results[$];
    t_est_in  cur_word;
    int       src_idle_pct = 0;
    int       snk_stall_pct = 0;
    int       errors = 0;
    longint   cycles = 0;

    longint  period_reg;
    longint  tau_reg;
    longint  imr_est;
    longint  slip_acc;
    longint  rot_acc;
    longint  flux_ang;
    longint  sync_spd;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clamp32((a * b) >>> FB);
    endfunction

    function automatic longint wrap2pi(longint a);
        longint r;
        r = a % TWO_PI_FX;
        if (r < 0) r += TWO_PI_FX;
        return r;
    endfunction

    task automatic load_start_state();
        imr_est = 1;
        slip_acc = 0;
        rot_acc = 0;
        flux_ang = 1;
        sync_spd = 1;
    endtask

    task automatic predict_step(t_est_in w);
        t_est_out e;
        longint ratio, diff, den, slip;
        e.fault = 1'b0;
        if (w.restart == ACT_RESTART) begin
            load_start_state();
        end else begin
            ratio = (tau_reg == 0) ? 64'sd2147483647 : clamp32((period_reg * ONE_FX) / tau_reg);
            diff = clamp32(longint'(w.ids) - imr_est);
            imr_est = clamp32(imr_est + qmul(ratio, diff));
            den = qmul(tau_reg, imr_est);
            if (den == 0) begin
                slip = (w.iqs < 0) ? -64'sd2147483648 : 64'sd2147483647;
                e.fault = 1'b1;
            end else begin
                slip = clamp32((longint'(w.iqs) * ONE_FX) / den);
            end
            sync_spd = clamp32(longint'(w.wr) + slip);
            slip_acc = wrap2pi(slip_acc + qmul(slip, period_reg));
            rot_acc = wrap2pi(rot_acc + qmul(longint'(w.wr), period_reg));
            flux_ang = wrap2pi(slip_acc + rot_acc);
        end
        e.angle = flux_ang[18:0];
        e.sync = sync_spd[31:0];
        e.imr = imr_est[31:0];
        expected_results.push_back(e);
    endtask

    // source: hold the word until accepted, then advance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_step(cur_word);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_word.wr, cur_word.ids, cur_word.iqs};
                    s_tuser <= cur_word.restart;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink: compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        t_est_out e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_tdata[18:0] !== e.angle) begin
                    $error("flux_angle exp %0d got %0d", e.angle, m_tdata[18:0]);
                    errors++;
                end
                if (m_tdata[50:19] !== e.sync) begin
                    $error("sync_speed exp %0d got %0d", e.sync, $signed(m_tdata[50:19]));
                    errors++;
                end
                if (m_tdata[82:51] !== e.imr) begin
                    $error("magnetizing_current exp %0d got %0d", e.imr,
                           $signed(m_tdata[82:51]));
                    errors++;
                end
                if (m_tuser[0] !== e.fault) begin
                    $error("divide_fault exp %0d got %0d", e.fault, m_tuser[0]);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_rotor_flux_angle_estimator: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [30:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == REG_STEP_PERIOD) period_reg = val;
        else tau_reg = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_word(logic r, logic [31:0] q, logic [31:0] d, logic [31:0] s);
        t_est_in w;
        w.restart = r;
        w.iqs = q;
        w.ids = d;
        w.wr = s;
        pending_words.push_back(w);
    endtask

    function automatic logic [31:0] pick_current();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(8 << FB)) - (4 << FB);
            2: return $signed($urandom_range(400)) - 200;
            default: return $signed($urandom_range(200 << FB)) - (100 << FB);
        endcase
    endfunction

    task automatic queue_random(int n);
        repeat (n) begin
            if ($urandom_range(99) < 4) queue_word(ACT_RESTART, $urandom, $urandom, $urandom);
            else queue_word(ACT_STEP, pick_current(), pick_current(), pick_current());
        end
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [30:0] per_set[6];
        logic [30:0] tau_set[6];
        period_reg = PERIOD_RST;
        tau_reg = TAU_RST;
        load_start_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, restart, zero divisor after restart
        queue_word(ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_word(ACT_STEP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_word(ACT_STEP, 32'h0, 32'h0, 32'h0);
        queue_word(ACT_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(ACT_STEP, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        queue_word(ACT_RESTART, 32'h0, 32'h0, 32'h0);
        queue_word(ACT_STEP, 32'h0001_0000, 32'h0, 32'h0);
        queue_word(ACT_STEP, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000);
        queue_word(ACT_STEP, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0064_0000);
        queue_word(ACT_STEP, 32'h0000_8000, 32'h8000_0000, 32'hFF9C_0000);
        queue_word(ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_word(ACT_RESTART, 32'h0, 32'h0, 32'h0);
        drain();
        write_reg(REG_STEP_PERIOD, REG_MAX);
        write_reg(REG_ROTOR_TAU, 31'd1);
        queue_word(ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_word(ACT_STEP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_word(ACT_STEP, 32'h1234_5678, 32'hFFFF_0000, 32'h0001_0000);
        drain();
        write_reg(REG_STEP_PERIOD, 31'd1);
        write_reg(REG_ROTOR_TAU, REG_MAX);
        queue_word(ACT_STEP, 32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF);
        queue_word(ACT_STEP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drain();

        per_set = '{31'd7, 31'd1, REG_MAX, 31'd1, REG_MAX, 31'd66};
        tau_set = '{31'd6554, 31'd1, REG_MAX, REG_MAX, 31'd1, 31'd13107};
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 84; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 84; end
                default: begin src_idle_pct = 33; snk_stall_pct = 33; end
            endcase
            if (ph < 6) begin
                write_reg(REG_STEP_PERIOD, per_set[ph]);
                write_reg(REG_ROTOR_TAU, tau_set[ph]);
            end else begin
                write_reg(REG_STEP_PERIOD, 31'($urandom_range(1, 2000)));
                write_reg(REG_ROTOR_TAU, 31'($urandom_range(1, 1 << 20)));
            end
            queue_random(200);
            drain();
        end

        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (400) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb_rotor_flux_angle_estimator: PASS");
        end else begin
            $display("tb_rotor_flux_angle_estimator: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
